// ===== hw/rtl/gpr_pkg.sv =====
// Shared constants, configuration and word types for the point-to-ring-cell block.
package gpr_pkg;

  localparam int MAX_HALF_SIDE = 256;
  localparam int Q_BITS        = $clog2(2 * MAX_HALF_SIDE);
  localparam int COORD_W       = 32;
  localparam int STEP_W        = 31;
  localparam int SIDE_W        = 9;
  localparam int IDX_W         = 9;
  localparam int ID_W          = 18;
  localparam int DIV_STAGES    = Q_BITS + 1;

  localparam logic [2:0] REG_LAT_MIN  = 3'd0;
  localparam logic [2:0] REG_LAT_MAX  = 3'd1;
  localparam logic [2:0] REG_LNG_MIN  = 3'd2;
  localparam logic [2:0] REG_LNG_MAX  = 3'd3;
  localparam logic [2:0] REG_LAT_STEP = 3'd4;
  localparam logic [2:0] REG_LNG_STEP = 3'd5;
  localparam logic [2:0] REG_HALF     = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] lat_min;
    logic [COORD_W-1:0] lat_max;
    logic [COORD_W-1:0] lng_min;
    logic [COORD_W-1:0] lng_max;
    logic [STEP_W-1:0]  lat_cell_step;
    logic [STEP_W-1:0]  lng_cell_step;
    logic [SIDE_W-1:0]  half_side;
  } cfg_t;

  typedef struct packed {
    logic               in_box;
    logic [COORD_W-1:0] lat_off;
    logic [COORD_W-1:0] lng_off;
  } mid_word_t;

  typedef struct packed {
    logic             in_box;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ID_W-1:0]  id;
  } res_word_t;

endpackage

// ===== hw/rtl/gpr_front.sv =====
// Front end: box test, offset calculation and the short queue towards the back end.
module gpr_front import gpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] lat_coord,
  input  logic [COORD_W-1:0] lng_coord,
  output logic               mid_valid,
  output mid_word_t          mid_word,
  input  logic               mid_pop
);

  mid_word_t   mem [0:3];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;
  logic        wr, rd;
  mid_word_t   w;
  logic [COORD_W:0] lat_d, lng_d;

  always_comb begin
    lat_d    = {lat_coord[COORD_W-1], lat_coord} - {cfg.lat_min[COORD_W-1], cfg.lat_min};
    lng_d    = {lng_coord[COORD_W-1], lng_coord} - {cfg.lng_min[COORD_W-1], cfg.lng_min};
    w.in_box = ($signed(lat_coord) >= $signed(cfg.lat_min)) &&
               ($signed(lat_coord) <= $signed(cfg.lat_max)) &&
               ($signed(lng_coord) >= $signed(cfg.lng_min)) &&
               ($signed(lng_coord) <= $signed(cfg.lng_max));
    // Inside the box both offsets are non-negative and fit in 32 bits.
    w.lat_off = lat_d[COORD_W-1:0];
    w.lng_off = lng_d[COORD_W-1:0];
  end

  assign full      = (cnt == 3'd4);
  assign mid_valid = (cnt != 3'd0);
  assign mid_word  = mem[rp];
  assign wr        = push && !full;
  assign rd        = mid_pop && mid_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'b00, wr} - {2'b00, rd};
    end
  end

endmodule

// ===== hw/rtl/gpr_div.sv =====
// Pipelined restoring divider, one quotient bit a stage, saturating above the grid size.
module gpr_div import gpr_pkg::*; (
  input  logic               clk,
  input  logic [COORD_W-1:0] off,
  input  logic [STEP_W-1:0]  step,
  output logic [Q_BITS-1:0]  q,
  output logic               sat
);

  localparam int WW = COORD_W + Q_BITS;

  logic [COORD_W-1:0] rem  [0:Q_BITS];
  logic [Q_BITS-1:0]  quo  [0:Q_BITS];
  logic               satr [0:Q_BITS];
  logic [WW-1:0]      lim;

  assign lim = {{(WW-STEP_W){1'b0}}, step} << Q_BITS;

  always_ff @(posedge clk) begin
    rem[0]  <= off;
    quo[0]  <= '0;
    satr[0] <= (step == '0) || ({{Q_BITS{1'b0}}, off} >= lim);
  end

  for (genvar k = 1; k <= Q_BITS; k++) begin : g_stage
    localparam int B = Q_BITS - k;
    logic [WW-1:0] dsh;
    logic          ge;
    assign dsh = {{(WW-STEP_W){1'b0}}, step} << B;
    assign ge  = ({{Q_BITS{1'b0}}, rem[k-1]} >= dsh);
    always_ff @(posedge clk) begin
      rem[k]  <= ge ? rem[k-1] - dsh[COORD_W-1:0] : rem[k-1];
      quo[k]  <= quo[k-1] | (ge ? (Q_BITS'(1) << B) : '0);
      satr[k] <= satr[k-1];
    end
  end

  assign q   = quo[Q_BITS];
  assign sat = satr[Q_BITS];

endmodule

// ===== hw/rtl/gpr_back.sv =====
// Back end: dividers, clamp, ring arithmetic and the result queue with credit control.
module gpr_back import gpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        mid_valid,
  input  mid_word_t   mid_word,
  output logic        mid_pop,
  output logic        empty,
  input  logic        pop,
  output res_word_t   res_word
);

  localparam int L  = DIV_STAGES + 2;
  localparam int SW = Q_BITS + 4;

  logic [L-1:0]      vld;
  logic [L-1:0]      inb;
  logic [4:0]        credits;
  logic              issue, rd;

  logic [Q_BITS-1:0] qx, qy;
  logic              sx, sy;
  logic [Q_BITS-1:0] s, top;
  logic [Q_BITS-1:0] xa, ya;

  logic signed [SW-1:0] dx, dy, rr, ss, edge_c;
  logic signed [SW-1:0] edge_b;
  logic [Q_BITS-1:0]    xb, yb;
  logic [2*Q_BITS-1:0]  sq_b;
  logic [Q_BITS-1:0]    rm1;
  logic [ID_W+1:0]      id_full;
  res_word_t            rw;

  res_word_t   mem [0:15];
  logic [3:0]  wp, rp;
  logic [4:0]  cnt;

  assign issue   = mid_valid && (credits != 5'd0);
  assign mid_pop = issue;

  gpr_div u_div_lat (
    .clk(clk), .off(mid_word.lat_off), .step(cfg.lat_cell_step), .q(qx), .sat(sx)
  );
  gpr_div u_div_lng (
    .clk(clk), .off(mid_word.lng_off), .step(cfg.lng_cell_step), .q(qy), .sat(sy)
  );

  always_comb begin
    if (cfg.half_side == '0) s = Q_BITS'(1);
    else if (32'(cfg.half_side) > MAX_HALF_SIDE) s = Q_BITS'(MAX_HALF_SIDE);
    else s = Q_BITS'(cfg.half_side);
    top = Q_BITS'({s, 1'b0} - 1);
  end

  // Clamp stage.
  always_ff @(posedge clk) begin
    xa <= (sx || qx > top) ? top : qx;
    ya <= (sy || qy > top) ? top : qy;
  end

  always_comb begin
    dx = $signed({{(SW-Q_BITS){1'b0}}, xa}) - $signed({{(SW-Q_BITS){1'b0}}, s});
    dy = $signed({{(SW-Q_BITS){1'b0}}, ya}) - $signed({{(SW-Q_BITS){1'b0}}, s});
    rr = -dx;
    if (dx + SW'(1) > rr) rr = dx + SW'(1);
    if (-dy > rr) rr = -dy;
    if (dy + SW'(1) > rr) rr = dy + SW'(1);
    ss  = rr;
    rm1 = Q_BITS'(ss - SW'(1));
    if (dy == -ss)                edge_c = dx + ss;
    else if (dx == ss - SW'(1))   edge_c = SW'(3) * ss + dy - SW'(1);
    else if (dy == ss - SW'(1))   edge_c = SW'(5) * ss - SW'(3) - dx;
    else                          edge_c = SW'(7) * ss - SW'(4) - dy;
  end

  // Ring stage: square of the inner rings and position along the ring.
  always_ff @(posedge clk) begin
    xb     <= xa;
    yb     <= ya;
    sq_b   <= rm1 * rm1;
    edge_b <= edge_c;
  end

  always_comb begin
    id_full   = {sq_b, 2'b00} + (ID_W+2)'(edge_b);
    rw.in_box = inb[L-1];
    rw.row    = inb[L-1] ? IDX_W'(xb) : '0;
    rw.col    = inb[L-1] ? IDX_W'(yb) : '0;
    rw.id     = inb[L-1] ? id_full[ID_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    inb <= {inb[L-2:0], mid_word.in_box};
  end

  assign empty    = (cnt == 5'd0);
  assign res_word = mem[rp];
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (vld[L-1]) begin
      mem[wp] <= rw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      credits <= 5'd16;
      wp      <= '0;
      rp      <= '0;
      cnt     <= '0;
    end else begin
      vld     <= {vld[L-2:0], issue};
      credits <= credits - {4'd0, issue} + {4'd0, rd};
      if (vld[L-1]) wp <= wp + 4'd1;
      if (rd) rp <= rp + 4'd1;
      cnt <= cnt + {4'd0, vld[L-1]} - {4'd0, rd};
    end
  end

endmodule

// ===== hw/rtl/geo_point_to_ring_cell_id_top.sv =====
// Top level of the point-to-ring-cell block: configuration registers and the two halves.
//
// Each word pushed in is one point (latitude, longitude, degrees times 2^22) and gives one
// result word: whether the point lies in the configured box, its row and column in the
// 2*half_side square grid, and its number in centre-outward ring order. A new point is
// taken every cycle while the front queue is not full; a point's result passes through the
// front queue, the two nine-stage dividers and their saturation check, and the clamp and
// ring stages, in that order, before it is written to the result queue. A four-word queue
// after the box test and a sixteen-word result queue, kept from overflowing by credits,
// let the input and output sides stall independently. Configuration writes are always
// accepted and should only be made while no points are in flight.
module geo_point_to_ring_cell_id_top import gpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] lat_coord,
  input  logic [COORD_W-1:0] lng_coord,
  output logic               empty,
  input  logic               pop,
  output logic               in_box,
  output logic [IDX_W-1:0]   row_index,
  output logic [IDX_W-1:0]   col_index,
  output logic [ID_W-1:0]    ring_cell_id,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t      cfg;
  logic      mid_valid, mid_pop;
  mid_word_t mid_word;
  res_word_t res_word;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_min       <= '0;
      cfg.lat_max       <= '0;
      cfg.lng_min       <= '0;
      cfg.lng_max       <= '0;
      cfg.lat_cell_step <= STEP_W'(1);
      cfg.lng_cell_step <= STEP_W'(1);
      cfg.half_side     <= SIDE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAT_MIN:  cfg.lat_min       <= cfg_data;
        REG_LAT_MAX:  cfg.lat_max       <= cfg_data;
        REG_LNG_MIN:  cfg.lng_min       <= cfg_data;
        REG_LNG_MAX:  cfg.lng_max       <= cfg_data;
        REG_LAT_STEP: cfg.lat_cell_step <= cfg_data[STEP_W-1:0];
        REG_LNG_STEP: cfg.lng_cell_step <= cfg_data[STEP_W-1:0];
        REG_HALF:     cfg.half_side     <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  gpr_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .full(full),
    .lat_coord(lat_coord), .lng_coord(lng_coord),
    .mid_valid(mid_valid), .mid_word(mid_word), .mid_pop(mid_pop)
  );

  gpr_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .mid_valid(mid_valid), .mid_word(mid_word),
    .mid_pop(mid_pop), .empty(empty), .pop(pop), .res_word(res_word)
  );

  assign in_box       = res_word.in_box;
  assign row_index    = res_word.row;
  assign col_index    = res_word.col;
  assign ring_cell_id = res_word.id;

endmodule
